/* hdl/pgsa_pkg.sv */
`timescale 1ns / 1ps
package pgsa_pkg;

	// defaults for the top level parameters
	localparam int SAMPLE_TIME_MS_DEF = 250;
	localparam int D_ALPHA_Q8_DEF     = 192;

	// one drive unit in the internal sum scale
	localparam logic signed [63:0] DRIVE_SCALE = 64'sd4096000;
	localparam logic [63:0] HALF_SCALE = 64'd2048000;
	// drive scale is 125 << 15
	localparam int SCALE_SHIFT = 15;
	localparam int SCALE_ODD   = 125;

	localparam int QUO_W = 28;

	// register indexes
	localparam logic [2:0] REG_KP       = 3'd0;
	localparam logic [2:0] REG_KI       = 3'd1;
	localparam logic [2:0] REG_KD       = 3'd2;
	localparam logic [2:0] REG_DEADBAND = 3'd3;
	localparam logic [2:0] REG_IBAND    = 3'd4;
	localparam logic [2:0] REG_ILIMIT   = 3'd5;
	localparam logic [2:0] REG_OLIMIT   = 3'd6;
	localparam logic [2:0] REG_SCHED    = 3'd7;

	localparam logic [15:0] KP_RST     = 16'd256;
	localparam logic [15:0] KI_RST     = 16'd0;
	localparam logic [15:0] KD_RST     = 16'd0;
	localparam logic [12:0] DEADBAND_RST = 13'd0;
	localparam logic [12:0] IBAND_RST  = 13'd160;
	localparam logic [30:0] ILIMIT_RST = 31'd1000000;
	localparam logic [14:0] OLIMIT_RST = 15'd1000;
	localparam logic [63:0] SCHED_RST  = 64'h0258_012C_00A0_0020;

	// datapath operations
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_LOAD = 4'd1;
	localparam logic [3:0] OP_PMUL = 4'd2;
	localparam logic [3:0] OP_PSCL = 4'd3;
	localparam logic [3:0] OP_FILT = 4'd4;
	localparam logic [3:0] OP_DMUL = 4'd5;
	localparam logic [3:0] OP_DSCL = 4'd6;
	localparam logic [3:0] OP_CAND = 4'd7;
	localparam logic [3:0] OP_IMUL = 4'd8;
	localparam logic [3:0] OP_ISUM = 4'd9;
	localparam logic [3:0] OP_ICMP = 4'd10;
	localparam logic [3:0] OP_TMUL = 4'd11;
	localparam logic [3:0] OP_TSUM = 4'd12;
	localparam logic [3:0] OP_TCLP = 4'd13;
	localparam logic [3:0] OP_QDIV = 4'd14;
	localparam logic [3:0] OP_OUT  = 4'd15;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} sts_t;

endpackage

/* hdl/pgsa_div.sv */
`timescale 1ns / 1ps
module pgsa_div #(
	parameter int DEN = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pgsa_pkg::QUO_W-1:0] num,
	output logic                       busy,
	output logic [pgsa_pkg::QUO_W-1:0] quo
);
	// division by a constant as a reciprocal multiply, exact for every QUO_W-bit numerator
	localparam int     SHIFT   = pgsa_pkg::QUO_W + $clog2(DEN);
	localparam int     RW      = pgsa_pkg::QUO_W + 1;
	localparam int     PW      = 2 * pgsa_pkg::QUO_W + 1;
	localparam longint RECIP   = ((64'sd1 <<< SHIFT) + longint'(DEN) - 64'sd1) / longint'(DEN);
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

	logic [pgsa_pkg::QUO_W-1:0] num_q;
	logic [pgsa_pkg::QUO_W-1:0] quo_q;
	logic                       busy_q;
	logic [PW-1:0]              prod;

	assign prod = num_q * RECIP_V;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
		end
		if (busy_q) begin
			quo_q <= pgsa_pkg::QUO_W'(prod >> SHIFT);
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

/* hdl/pgsa_dp.sv */
`timescale 1ns / 1ps
module pgsa_dp #(
	parameter int SAMPLE_TIME_MS = pgsa_pkg::SAMPLE_TIME_MS_DEF,
	parameter int D_ALPHA_Q8     = pgsa_pkg::D_ALPHA_Q8_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_addr,
	input  logic [63:0]         cfg_data,
	input  logic signed [13:0]  target_temp,
	input  logic signed [13:0]  measured_temp,
	input  pgsa_pkg::cmd_t      cmd,
	output pgsa_pkg::sts_t      sts,
	output logic signed [15:0]  drive
);
	localparam logic signed [9:0]  ALPHA = 10'(D_ALPHA_Q8);
	localparam logic signed [9:0]  BETA  = 10'(256 - D_ALPHA_Q8);
	localparam logic signed [33:0] TS    = 34'(SAMPLE_TIME_MS);

	logic [15:0] kp_q, ki_q, kd_q;
	logic [12:0] deadband_q, iband_q;
	logic [30:0] ilim_q;
	logic [14:0] olim_q;
	logic [63:0] sched_q;

	logic signed [31:0] acc_q, rf_q, cand_q;
	logic signed [13:0] prev_q, meas_q;
	logic signed [14:0] w_q;
	logic               int_en_q, dneg_q, neg_q;
	logic [15:0]        lim_q, cap_q;
	logic signed [63:0] lims_q, caps_q, pd_q, t_q;
	logic signed [49:0] prod_q;
	logic signed [15:0] drive_q;

	// load stage
	logic signed [14:0] tgt_x, meas_x, err, diff;
	logic [14:0]        aerr, dmag;
	logic [15:0]        lim_n;
	logic signed [14:0] w_n;

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [63:0] prod64;

	logic signed [28:0] rate;
	logic signed [41:0] filt;
	logic signed [33:0] csum, ilim_x;
	logic               high, low;
	logic [63:0]        mag;

	logic                       rdiv_start, rdiv_busy, qdiv_start, qdiv_busy;
	logic [pgsa_pkg::QUO_W-1:0] rdiv_num, rdiv_quo, qdiv_num, qdiv_quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= pgsa_pkg::KP_RST;
			ki_q       <= pgsa_pkg::KI_RST;
			kd_q       <= pgsa_pkg::KD_RST;
			deadband_q <= pgsa_pkg::DEADBAND_RST;
			iband_q    <= pgsa_pkg::IBAND_RST;
			ilim_q     <= pgsa_pkg::ILIMIT_RST;
			olim_q     <= pgsa_pkg::OLIMIT_RST;
			sched_q    <= pgsa_pkg::SCHED_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				pgsa_pkg::REG_KP:       kp_q       <= cfg_data[15:0];
				pgsa_pkg::REG_KI:       ki_q       <= cfg_data[15:0];
				pgsa_pkg::REG_KD:       kd_q       <= cfg_data[15:0];
				pgsa_pkg::REG_DEADBAND: deadband_q <= cfg_data[12:0];
				pgsa_pkg::REG_IBAND:    iband_q    <= cfg_data[12:0];
				pgsa_pkg::REG_ILIMIT:   ilim_q     <= cfg_data[30:0];
				pgsa_pkg::REG_OLIMIT:   olim_q     <= cfg_data[14:0];
				pgsa_pkg::REG_SCHED:    sched_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		tgt_x  = {target_temp[13], target_temp};
		meas_x = {measured_temp[13], measured_temp};
		err    = tgt_x - meas_x;
		aerr   = err[14] ? 15'(-err) : 15'(err);
		w_n    = (aerr <= {2'b0, deadband_q}) ? '0 : err;
		diff   = meas_x - {prev_q[13], prev_q};
		dmag   = diff[14] ? 15'(-diff) : 15'(diff);
		if ({1'b0, aerr} <= sched_q[15:0]) begin
			lim_n = sched_q[47:32];
		end else if ({1'b0, aerr} <= sched_q[31:16]) begin
			lim_n = sched_q[63:48];
		end else begin
			lim_n = {1'b0, olim_q};
		end
	end

	always_comb begin
		case (cmd.op)
			pgsa_pkg::OP_PMUL: begin
				mul_a = {{18{w_q[14]}}, w_q};
				mul_b = {1'b0, kp_q};
			end
			pgsa_pkg::OP_DMUL: begin
				mul_a = {rf_q[31], rf_q};
				mul_b = {1'b0, kd_q};
			end
			pgsa_pkg::OP_IMUL: begin
				mul_a = {cand_q[31], cand_q};
				mul_b = {1'b0, ki_q};
			end
			pgsa_pkg::OP_TMUL: begin
				mul_a = {acc_q[31], acc_q};
				mul_b = {1'b0, ki_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p  = mul_a * mul_b;
	assign prod64 = {{14{prod_q[49]}}, prod_q};

	always_comb begin
		rate   = dneg_q ? -$signed({1'b0, rdiv_quo}) : $signed({1'b0, rdiv_quo});
		filt   = {{10{rf_q[31]}}, rf_q} * ALPHA + {{13{rate[28]}}, rate} * BETA;
		csum   = {{2{acc_q[31]}}, acc_q} + {{19{w_q[14]}}, w_q} * TS;
		ilim_x = {3'b0, ilim_q};
		high   = t_q > lims_q;
		low    = t_q < -lims_q;
		mag    = (t_q[63] ? 64'(-t_q) : 64'(t_q)) + pgsa_pkg::HALF_SCALE;
	end

	// rate scaling by the sample time, then rounding by the odd part of the scale
	assign rdiv_start = cmd.op == pgsa_pkg::OP_LOAD;
	assign rdiv_num   = pgsa_pkg::QUO_W'(dmag) * pgsa_pkg::QUO_W'(16000);
	assign qdiv_start = cmd.op == pgsa_pkg::OP_QDIV;
	assign qdiv_num   = mag[pgsa_pkg::SCALE_SHIFT +: pgsa_pkg::QUO_W];

	pgsa_div #(
		.DEN (SAMPLE_TIME_MS)
	) u_rate_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rdiv_start),
		.num    (rdiv_num),
		.busy   (rdiv_busy),
		.quo    (rdiv_quo)
	);

	pgsa_div #(
		.DEN (pgsa_pkg::SCALE_ODD)
	) u_round_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (qdiv_start),
		.num    (qdiv_num),
		.busy   (qdiv_busy),
		.quo    (qdiv_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			rf_q   <= '0;
			prev_q <= '0;
		end else begin
			case (cmd.op)
				pgsa_pkg::OP_FILT: rf_q <= filt[39:8];
				pgsa_pkg::OP_ICMP: begin
					if (int_en_q && (!high || w_q[14]) && (!low || (!w_q[14] && w_q != 0)))
						acc_q <= cand_q;
				end
				pgsa_pkg::OP_OUT: prev_q <= meas_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			pgsa_pkg::OP_LOAD: begin
				meas_q   <= measured_temp;
				w_q      <= w_n;
				int_en_q <= (w_n != 0) && (aerr <= {2'b0, iband_q});
				dneg_q   <= diff[14];
				lim_q    <= lim_n;
				cap_q    <= (lim_n < {1'b0, olim_q}) ? lim_n : {1'b0, olim_q};
			end
			pgsa_pkg::OP_PMUL, pgsa_pkg::OP_DMUL, pgsa_pkg::OP_IMUL,
			pgsa_pkg::OP_TMUL: prod_q <= mul_p;
			pgsa_pkg::OP_PSCL: pd_q <= prod64 * 64'sd16000;
			pgsa_pkg::OP_DSCL: pd_q <= pd_q - prod64 * 64'sd1000;
			pgsa_pkg::OP_CAND: begin
				if (csum > ilim_x) begin
					cand_q <= 32'(ilim_x);
				end else if (csum < -ilim_x) begin
					cand_q <= 32'(-ilim_x);
				end else begin
					cand_q <= csum[31:0];
				end
				lims_q <= $signed({48'b0, lim_q}) * pgsa_pkg::DRIVE_SCALE;
				caps_q <= $signed({48'b0, cap_q}) * pgsa_pkg::DRIVE_SCALE;
			end
			pgsa_pkg::OP_ISUM, pgsa_pkg::OP_TSUM: t_q <= pd_q + (prod64 <<< 4);
			pgsa_pkg::OP_TCLP: begin
				if (t_q > caps_q) begin
					t_q <= caps_q;
				end else if (t_q < -caps_q) begin
					t_q <= -caps_q;
				end
			end
			pgsa_pkg::OP_QDIV: neg_q <= t_q[63];
			pgsa_pkg::OP_OUT: begin
				drive_q <= neg_q ? -$signed(qdiv_quo[15:0]) : $signed(qdiv_quo[15:0]);
			end
			default: ;
		endcase
	end

	assign sts.div_busy = rdiv_busy | qdiv_busy;
	assign drive        = drive_q;
endmodule

/* hdl/pgsa_ctrl.sv */
`timescale 1ns / 1ps
module pgsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output pgsa_pkg::cmd_t cmd,
	input  pgsa_pkg::sts_t sts
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PMUL  = 4'd1;
	localparam logic [3:0] ST_PSCL  = 4'd2;
	localparam logic [3:0] ST_DWAIT = 4'd3;
	localparam logic [3:0] ST_FILT  = 4'd4;
	localparam logic [3:0] ST_DMUL  = 4'd5;
	localparam logic [3:0] ST_DSCL  = 4'd6;
	localparam logic [3:0] ST_CAND  = 4'd7;
	localparam logic [3:0] ST_IMUL  = 4'd8;
	localparam logic [3:0] ST_ISUM  = 4'd9;
	localparam logic [3:0] ST_ICMP  = 4'd10;
	localparam logic [3:0] ST_TMUL  = 4'd11;
	localparam logic [3:0] ST_TSUM  = 4'd12;
	localparam logic [3:0] ST_TCLP  = 4'd13;
	localparam logic [3:0] ST_QDIV  = 4'd14;
	localparam logic [3:0] ST_QWAIT = 4'd15;

	logic [3:0] state_q, state_n;
	logic       out_valid_q;
	logic       take, finish;

	assign in_ready = state_q == ST_IDLE;
	assign take     = in_valid && in_ready;
	// result register is free or being emptied this cycle
	assign finish   = state_q == ST_QWAIT && !sts.div_busy && (!out_valid_q || out_ready);

	always_comb begin
		state_n = state_q;
		cmd.op  = pgsa_pkg::OP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cmd.op  = pgsa_pkg::OP_LOAD;
					state_n = ST_PMUL;
				end
			end
			ST_PMUL:  begin cmd.op = pgsa_pkg::OP_PMUL; state_n = ST_PSCL; end
			ST_PSCL:  begin cmd.op = pgsa_pkg::OP_PSCL; state_n = ST_DWAIT; end
			ST_DWAIT: begin
				if (!sts.div_busy) state_n = ST_FILT;
			end
			ST_FILT:  begin cmd.op = pgsa_pkg::OP_FILT; state_n = ST_DMUL; end
			ST_DMUL:  begin cmd.op = pgsa_pkg::OP_DMUL; state_n = ST_DSCL; end
			ST_DSCL:  begin cmd.op = pgsa_pkg::OP_DSCL; state_n = ST_CAND; end
			ST_CAND:  begin cmd.op = pgsa_pkg::OP_CAND; state_n = ST_IMUL; end
			ST_IMUL:  begin cmd.op = pgsa_pkg::OP_IMUL; state_n = ST_ISUM; end
			ST_ISUM:  begin cmd.op = pgsa_pkg::OP_ISUM; state_n = ST_ICMP; end
			ST_ICMP:  begin cmd.op = pgsa_pkg::OP_ICMP; state_n = ST_TMUL; end
			ST_TMUL:  begin cmd.op = pgsa_pkg::OP_TMUL; state_n = ST_TSUM; end
			ST_TSUM:  begin cmd.op = pgsa_pkg::OP_TSUM; state_n = ST_TCLP; end
			ST_TCLP:  begin cmd.op = pgsa_pkg::OP_TCLP; state_n = ST_QDIV; end
			ST_QDIV:  begin cmd.op = pgsa_pkg::OP_QDIV; state_n = ST_QWAIT; end
			ST_QWAIT: begin
				if (finish) begin
					cmd.op  = pgsa_pkg::OP_OUT;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

/* hdl/pid_gain_scheduled_antiwindup.sv */
`timescale 1ns / 1ps
// PID temperature controller: one drive value per (target, measured) sample, with
// deadband, filtered derivative on the measurement, conditional integration and a
// limit scheduled by error size and capped by output_limit. One sample is worked
// at a time: a new sample is taken only once the last result has gone to the
// output register. The controller steps the datapath through its operations in
// order, some of them on a shared multiplier; each division by a constant (rate
// scaling by the sample time, rounding to drive units) is a reciprocal multiply.
// The next input transfer is taken as soon as the result sits in the output
// register, which holds it until the downstream side takes it; a result still
// waiting there stalls the last step of the following sample.
module pid_gain_scheduled_antiwindup #(
	parameter int SAMPLE_TIME_MS = pgsa_pkg::SAMPLE_TIME_MS_DEF,
	parameter int D_ALPHA_Q8     = pgsa_pkg::D_ALPHA_Q8_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // target_temp[13:0], measured_temp[27:14], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // drive[15:0]
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_addr,
	input  logic [63:0] cfg_data
);
	pgsa_pkg::cmd_t     cmd;
	pgsa_pkg::sts_t     sts;
	logic signed [15:0] drive;

	pgsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pgsa_dp #(
		.SAMPLE_TIME_MS (SAMPLE_TIME_MS),
		.D_ALPHA_Q8     (D_ALPHA_Q8)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.target_temp   ($signed(s_axis_tdata[13:0])),
		.measured_temp ($signed(s_axis_tdata[27:14])),
		.cmd           (cmd),
		.sts           (sts),
		.drive         (drive)
	);

	assign m_axis_tdata = drive;

`ifndef SYNTHESIS
	// one sample in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while a sample is in work");

	// drive magnitude never exceeds 32767
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata != 16'h8000)
		else $error("drive out of range");

	// a new result appears only after the sample was worked
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without work");
`endif
endmodule
